>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int StackDepth = 32;
  localparam int PtrW       = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MOD   = 8'h25;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_BADSYM  = 3'd4,
    ST_POWOVF  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_DIV = 2'd0,
    OP_MOD = 2'd1,
    OP_POW = 2'd2
  } iop_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_TOP,
    S_OUT
  } state_t;

  // Request to and answer from the iterative arithmetic unit.
  typedef struct packed {
    logic        start;
    iop_t        op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } iu_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] res;
  } iu_rsp_t;

endpackage

>>> rtl/pfe_iter_unit.sv
// ----------------------------------------------------------------------------
// pfe_iter_unit
// Multicycle signed divide, remainder and saturating power.
// ----------------------------------------------------------------------------
module pfe_iter_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  pfe_pkg::iu_req_t req,
  output pfe_pkg::iu_rsp_t rsp
);
  import pfe_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  iop_t        op_r, op_nxt;
  logic [31:0] quo_r, quo_nxt;    // dividend bits shifting out, quotient in
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;    // divisor magnitude / power base
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;

  logic [31:0] la, ra;
  logic [32:0] trial;
  logic signed [63:0] prod;
  logic signed [31:0] bs, es;

  assign la = req.lhs[31] ? (~req.lhs + 32'd1) : req.lhs;
  assign ra = req.rhs[31] ? (~req.rhs + 32'd1) : req.rhs;
  assign trial = {rem_r[31:0], quo_r[31]} - {1'b0, dvs_r};
  // The accumulator always holds an in-range power, so 32 by 32 bits suffice.
  assign prod  = acc_r * $signed(dvs_r);
  assign bs = $signed(req.lhs);
  assign es = $signed(req.rhs);

  always_comb begin
    busy_nxt = busy_r;  cnt_nxt = cnt_r;  op_nxt = op_r;
    quo_nxt = quo_r;  rem_nxt = rem_r;  dvs_nxt = dvs_r;
    qneg_nxt = qneg_r;  rneg_nxt = rneg_r;  acc_nxt = acc_r;
    ovf_nxt = ovf_r;  done_nxt = 1'b0;  res_nxt = res_r;
    if (req.start) begin
      op_nxt = req.op;
      ovf_nxt = 1'b0;
      busy_nxt = 1'b1;
      if (req.op == OP_POW) begin
        dvs_nxt = req.lhs;
        acc_nxt = 32'sd1;
        cnt_nxt = req.rhs[5:0];
        // Special exponents and bases finish at once.
        if (es == 0 || bs == 1) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; res_nxt = 32'd1;
        end else if (bs == -1) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
          res_nxt = req.rhs[0] ? 32'hFFFF_FFFF : 32'd1;
        end else if (bs == 0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
          res_nxt = es < 0 ? 32'h7FFF_FFFF : 32'd0;
          ovf_nxt = es < 0;
        end else if (es < 0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; res_nxt = 32'd0;
        end else if (es >= 32) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; ovf_nxt = 1'b1;
          res_nxt = (bs < 0 && req.rhs[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        qneg_nxt = bs < 0 && req.rhs[0];
      end else begin
        quo_nxt = la;
        rem_nxt = '0;
        dvs_nxt = ra;
        cnt_nxt = 6'd32;
        qneg_nxt = req.lhs[31] ^ req.rhs[31];
        rneg_nxt = req.lhs[31];
      end
    end else if (busy_r) begin
      if (op_r == OP_POW) begin
        if (cnt_r == 6'd0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; res_nxt = acc_r;
        end else if (prod > 64'sh7FFF_FFFF || prod < -64'sh8000_0000) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; ovf_nxt = 1'b1;
          res_nxt = qneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          acc_nxt = $signed(prod[31:0]);
          cnt_nxt = cnt_r - 6'd1;
        end
      end else if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (op_r == OP_DIV) res_nxt = qneg_r ? (~quo_r + 32'd1) : quo_r;
        else res_nxt = rneg_r ? (~rem_r[31:0] + 32'd1) : rem_r[31:0];
      end else begin
        // One restoring step per cycle.
        if (!trial[32]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;  op_r <= op_nxt;  quo_r <= quo_nxt;  rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;  qneg_r <= qneg_nxt;  rneg_r <= rneg_nxt;
    acc_r <= acc_nxt;  ovf_r <= ovf_nxt;  res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.res  = res_r;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("unit done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("unit started while busy");
  a_ovf_pow: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && ovf_r) |-> op_r == OP_POW) else $error("overflow outside power");
`endif

endmodule

>>> rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator with its operand stack in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one character (in_symbol) per item, with
// in_last marking the end of an expression. Digits push, operators pop two
// operands and push the result. After the last item one result item with
// out_value and out_status leaves on the output channel, and the stack and
// the sticky error are cleared.
// Timing: one item at a time. A digit or invalid symbol passes S_READ, an
// add, subtract, multiply or divide by zero also S_EXEC, and divide,
// remainder and power then S_WAIT, on the one-bit-per-cycle divider or one
// multiply per exponent step. A last item adds S_TOP for the top-of-stack
// read. The result sits in an output register; the next item is accepted
// while it waits, and only a second last item waits for out_stall to drop.
// Reset clears the pointer, error and handshake state; the stack memory
// needs no clearing pass because only written entries are ever read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]  out_status
);
  import pfe_pkg::*;

  logic [31:0] mem [StackDepth];
  logic [31:0] rd_r;
  logic [AddrW-1:0] ra_addr;
  logic        we;
  logic [AddrW-1:0] wa;
  logic [31:0] wd;

  state_t      state_r, state_nxt;
  logic [PtrW-1:0] sp_r, sp_nxt;
  status_t     err_r, err_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic        last_r, last_nxt;
  logic [31:0] rop_r, rop_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] oval_r, oval_nxt;
  status_t     ost_r, ost_nxt;

  iu_req_t req;
  iu_rsp_t rsp;

  logic is_digit, is_op, is_iter, accept;
  logic [31:0] alu;

  pfe_iter_unit u_iter (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign accept   = in_valid && !in_stall;
  assign is_digit = sym_r inside {[CH_ZERO:CH_NINE]};
  assign is_op    = sym_r inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW, CH_MOD};
  assign is_iter  = sym_r inside {CH_DIV, CH_POW, CH_MOD};

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra_addr];
  end

  // In the execute cycle rd_r holds the left operand and rop_r the right one.
  always_comb begin
    case (sym_r)
      CH_PLUS:  alu = rd_r + rop_r;
      CH_MINUS: alu = rd_r - rop_r;
      CH_MUL:   alu = rd_r * rop_r;
      default:  alu = rop_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: begin
        if (err_r != ST_OK || !is_op || sp_r < PtrW'(2))
          state_nxt = last_r ? S_TOP : S_IDLE;
        else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (is_iter && (sym_r == CH_POW || rop_r != '0)) state_nxt = S_WAIT;
        else state_nxt = last_r ? S_TOP : S_IDLE;
      end
      S_WAIT: if (rsp.done) state_nxt = last_r ? S_TOP : S_IDLE;
      S_TOP:  state_nxt = S_OUT;
      S_OUT:  if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    sp_nxt = sp_r;  err_nxt = err_r;  sym_nxt = sym_r;  last_nxt = last_r;
    rop_nxt = rop_r;  oval_nxt = oval_r;  ost_nxt = ost_r;
    ov_nxt = ov_r && out_stall;
    in_stall = state_r != S_IDLE;
    we = 1'b0;  wa = sp_r[AddrW-1:0];  wd = {24'd0, sym_r - CH_ZERO};
    ra_addr = AddrW'(sp_r - PtrW'(1));
    req = '0;
    req.lhs = rop_r;  req.rhs = rd_r;
    case (sym_r)
      CH_DIV:  req.op = OP_DIV;
      CH_MOD:  req.op = OP_MOD;
      default: req.op = OP_POW;
    endcase
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sym_nxt = in_symbol;
          last_nxt = in_last;
        end
      end
      S_READ: begin
        // Right operand read was issued last cycle; now fetch the left one.
        ra_addr = AddrW'(sp_r - PtrW'(2));
        rop_nxt = rd_r;
        if (err_r == ST_OK) begin
          if (is_digit) begin
            if (sp_r >= PtrW'(StackDepth)) err_nxt = ST_OVER;
            else begin
              we = 1'b1;
              sp_nxt = sp_r + PtrW'(1);
            end
          end else if (!is_op) err_nxt = ST_BADSYM;
          else if (sp_r < PtrW'(2)) err_nxt = ST_UNDER;
        end
      end
      S_EXEC: begin
        // rop_r holds the right operand, rd_r the left one; swap roles.
        req.lhs = rd_r;  req.rhs = rop_r;
        wa = AddrW'(sp_r - PtrW'(2));
        if (is_iter) begin
          if (sym_r != CH_POW && rop_r == '0) err_nxt = ST_DIVZERO;
          else begin
            req.start = 1'b1;
            sp_nxt = sp_r - PtrW'(1);
          end
        end else begin
          we = 1'b1;
          wd = alu;
          sp_nxt = sp_r - PtrW'(1);
        end
      end
      S_WAIT: begin
        wa = AddrW'(sp_r - PtrW'(1));
        wd = rsp.res;
        if (rsp.done) begin
          we = 1'b1;
          if (rsp.ovf) err_nxt = ST_POWOVF;
        end
      end
      S_TOP: ;
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          if (sp_r != '0) begin
            oval_nxt = rd_r;
            ost_nxt = err_r;
          end else begin
            oval_nxt = '0;
            ost_nxt = (err_r == ST_OK) ? ST_UNDER : err_r;
          end
          sp_nxt = '0;
          err_nxt = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r <= '0;
      err_r <= ST_OK;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      err_r <= err_nxt;
      ov_r <= ov_nxt;
    end
    sym_r <= sym_nxt;  last_r <= last_nxt;  rop_r <= rop_nxt;
    oval_r <= oval_nxt;  ost_r <= ost_nxt;
  end

  assign out_valid  = ov_r;
  assign out_value  = oval_r;
  assign out_status = ost_r;

`ifndef NO_ASSERTIONS
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PtrW'(StackDepth)) else $error("stack pointer out of range");
  a_write_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == S_READ) |-> err_r == ST_OK) else $error("push after error");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("item taken while busy");
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE) |=> sp_r == '0)
    else $error("stack not cleared after result");
`endif

endmodule

>>> sim/tb_postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking bench: postfix expressions are fed one character per item,
// a behavioral evaluator predicts each result, and a monitor compares it.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  import pfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } char_t;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_symbol;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] out_value;
  logic [2:0]  out_status;

  postfix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_symbol(in_symbol), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  char_t   pending_chars[$];
  answer_t expected_answers[$];

  logic [31:0] eval_stack[StackDepth];
  int          eval_sp;
  status_t     eval_err;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_sender;
  int  errors;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating integer power; the flag reports saturation.
  function automatic logic [31:0] power_of(logic [31:0] lhs, logic [31:0] rhs,
                                           output bit ovf);
    longint b;
    longint e;
    longint acc;
    b = longint'($signed(lhs));
    e = longint'($signed(rhs));
    acc = 1;
    ovf = 1'b0;
    if (e == 0 || b == 1) return 32'd1;
    if (b == -1) return e[0] ? 32'hFFFF_FFFF : 32'd1;
    if (b == 0) begin
      if (e < 0) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return 32'd0;
    end
    if (e < 0) return 32'd0;
    if (e < 32) begin
      for (longint k = 0; k < e; k++) begin
        acc = acc * b;
        if (acc > 64'sd2147483647 || acc < -64'sd2147483648) break;
      end
      if (acc <= 64'sd2147483647 && acc >= -64'sd2147483648) return acc[31:0];
    end
    ovf = 1'b1;
    return (b < 0 && e[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic void eval_symbol(logic [7:0] sym);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] res;
    bit ovf;
    ovf = 1'b0;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (eval_sp >= StackDepth) begin
        eval_err = ST_OVER;
        return;
      end
      eval_stack[eval_sp] = 32'(sym - CH_ZERO);
      eval_sp++;
      return;
    end
    if (!(sym inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW, CH_MOD})) begin
      eval_err = ST_BADSYM;
      return;
    end
    if (eval_sp < 2) begin
      eval_err = ST_UNDER;
      return;
    end
    r = eval_stack[eval_sp-1];
    l = eval_stack[eval_sp-2];
    if ((sym == CH_DIV || sym == CH_MOD) && r == 0) begin
      eval_err = ST_DIVZERO;
      return;
    end
    case (sym)
      CH_PLUS:  res = l + r;
      CH_MINUS: res = l - r;
      CH_MUL:   res = l * r;
      // Widening avoids the trap on the most negative value divided by -1.
      CH_DIV:   res = 32'(longint'($signed(l)) / longint'($signed(r)));
      CH_MOD:   res = 32'(longint'($signed(l)) % longint'($signed(r)));
      default:  res = power_of(l, r, ovf);
    endcase
    eval_sp--;
    eval_stack[eval_sp-1] = res;
    if (ovf) eval_err = ST_POWOVF;
  endfunction

  function automatic void evaluate_char(char_t c);
    answer_t a;
    if (eval_err == ST_OK) eval_symbol(c.symbol);
    if (!c.last) return;
    a.status = eval_err;
    a.value = 32'd0;
    if (eval_sp > 0) a.value = eval_stack[eval_sp-1];
    else if (eval_err == ST_OK) a.status = ST_UNDER;
    expected_answers.push_back(a);
    eval_sp = 0;
    eval_err = ST_OK;
  endfunction

  // Driver: keeps a stalled item steady and advances only on acceptance.
  // With hold_sender, no item follows a last one until all results are in.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) evaluate_char('{in_symbol, in_last});
      if (pending_chars.size() > 0 &&
          !(hold_sender && (expected_answers.size() > 0 || (in_valid && in_last))) &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_symbol <= pending_chars[0].symbol;
        in_last   <= pending_chars[0].last;
        void'(pending_chars.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d",
                   $realtime, out_value, out_status);
          errors++;
        end else begin
          if (out_value !== expected_answers[0].value)
            begin
            $display("%0t: value expected %0d actual %0d", $realtime,
                     $signed(expected_answers[0].value), out_value);
            errors++;
          end
          if (out_status !== expected_answers[0].status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     expected_answers[0].status, out_status);
            errors++;
          end
          void'(expected_answers.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void add_char(logic [7:0] s, logic l);
    pending_chars.push_back('{s, l});
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k], k == s.len() - 1);
  endfunction

  function automatic logic [7:0] any_op();
    case ($urandom_range(5))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_MUL;
      3: return CH_DIV;
      4: return CH_POW;
      default: return CH_MOD;
    endcase
  endfunction

  // Pushes and operators balanced to one value, then an operator or a digit.
  function automatic void add_expression();
    int depth;
    int n;
    depth = 0;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      if (depth >= 2 && ($urandom_range(1) == 1 || depth > 6)) begin
        add_char(any_op(), 1'b0);
        depth--;
      end else begin
        add_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
        depth++;
      end
    end
    while (depth > 1) begin
      add_char(any_op(), 1'b0);
      depth--;
    end
    if ($urandom_range(9) == 0) add_char(CH_ZERO + 8'($urandom_range(9)), 1'b1);
    else add_char(any_op(), 1'b1);
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(2) == 0) add_char(8'($urandom), 1'b0);
      else if ($urandom_range(1)) add_char(any_op(), 1'b0);
      else add_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    end
    add_char(8'($urandom), 1'b1);
  endfunction

  task automatic drain();
    while (pending_chars.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic run_random(int items);
    int target;
    target = pending_chars.size() + items;
    while (pending_chars.size() < target) begin
      if ($urandom_range(9) < 8) add_expression();
      else add_noise();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_symbol = 8'd0;
    in_last = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_sender = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    eval_sp = 0;
    eval_err = ST_OK;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_text("34+");
    add_text("29-");
    add_text("97*");
    add_text("72/");
    add_text("72%");
    add_text("23^");
    add_text("+");
    add_text("90/");
    add_text("a");
    add_char(8'hFF, 1'b1);
    add_char(8'h00, 1'b1);
    add_text("99*9*9*9*9*9*9*9*9*9*");
    add_text("09-2^");
    add_text("09-32-^");
    add_text("01-9^");
    add_text("01-2^");
    add_text("34-2^");
    add_text("0");
    drain();
    // A power and multiply chain, then a divide with only one operand.
    add_text("02-33^3*3*3*7*9*2*+1-");
    add_text("01-/");
    add_text("99^99^^");
    add_text("09-9^");
    add_text("45");
    for (int k = 0; k < StackDepth + 1; k++) add_char(CH_ZERO + 8'(k % 10), 1'b0);
    add_char(CH_PLUS, 1'b1);
    drain();

    run_random(450);
    hold_sender = 1'b1;
    add_text("58+");
    add_text("93-");
    add_text("0/");
    drain();
    hold_sender = 1'b0;
    send_idle_pct = 53;
    run_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    run_random(400);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(400);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
